### rtl/core/stmf_pkg.sv
// stmf_pkg: shared types and constants for the sorted trimmed mean filter
// no dependencies
`timescale 1ns / 1ps
package stmf_pkg;

  localparam int LEN_BITS    = 5;
  localparam int TRIM_BITS   = 4;
  localparam int THR_BITS    = 15;
  localparam int OUT_BITS    = 16;
  localparam int STATUS_BITS = 2;

  typedef enum logic [1:0] {
    REG_TOTAL_LENGTH   = 2'd0,
    REG_TRIM_COUNT     = 2'd1,
    REG_ZERO_THRESHOLD = 2'd2,
    REG_NONE           = 2'd3
  } reg_index_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CFG  = 2'd1,
    ST_CORE_LOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT,
    S_SUM,
    S_DIV,
    S_OUT
  } fsm_t;

  // control given to every cell of the row of sort cells
  typedef struct packed {
    logic clear;
    logic shift;
    logic sort;
  } cell_ctl_t;

endpackage

### rtl/core/sorted_trimmed_mean_filter_unit.sv
// sorted_trimmed_mean_filter_unit: top level of the trimmed mean filter
// depends on stmf_pkg, stmf_cell, stmf_div
`timescale 1ns / 1ps
// Sliding-window trimmed mean filter. Each s_axis transfer carries one signed
// sample that shifts into a history of total_length slots held in a row of
// MAX_DEPTH cells. The window is copied into a sorted row and sorted in place
// by odd-even transposition (MAX_DEPTH passes), the kept core between
// trim_count and total_length-trim_count-1 is summed with inner samples
// doubled (one cell per cycle), and the sum is divided by 2*(N-1) in a
// restoring divider, one quotient bit per cycle. A full result passes the
// check state, the sort row, the summing walk and the divider with its done
// flag before it reaches the output register; the next sample is taken only
// once that result has been taken. Bad configuration or a kept core under
// two gives a result in the cycle after its transfer and leaves the history
// alone. A warm-up result (oldest |sample| below zero_threshold) is
// registered from the check state after the shift, with no sort run. One
// item is in flight at a time; the result waits in an output register until
// taken. Any write to a listed register clears the history.
module sorted_trimmed_mean_filter_unit #(
  parameter int MAX_DEPTH   = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,   // sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,   // filtered, status, warming
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [31:0]            cfg_data
);
  import stmf_pkg::*;

  localparam int IdxBits  = $clog2(MAX_DEPTH);
  localparam int CntBits  = $clog2(MAX_DEPTH + 1);
  localparam int SumBits  = SAMPLE_BITS + CntBits + 2;
  localparam int DenBits  = CntBits + 2;

  // configuration registers
  logic [LEN_BITS-1:0]  total_length;
  logic [TRIM_BITS-1:0] trim_count;
  logic [THR_BITS-1:0]  zero_threshold;
  logic                 cfg_hit;

  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && (cfg_index != REG_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length   <= LEN_BITS'(5);
      trim_count     <= TRIM_BITS'(1);
      zero_threshold <= THR_BITS'(1);
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_TOTAL_LENGTH:   total_length   <= cfg_data[LEN_BITS-1:0];
        REG_TRIM_COUNT:     trim_count     <= cfg_data[TRIM_BITS-1:0];
        REG_ZERO_THRESHOLD: zero_threshold <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // configuration checks
  logic [LEN_BITS:0] two_w;
  logic [LEN_BITS:0] n_keep;
  logic              bad_cfg;
  logic              low_core;

  assign two_w    = {1'b0, trim_count, 1'b0};
  assign bad_cfg  = (trim_count == '0) || ({1'b0, total_length} < two_w) ||
                    (32'(total_length) > 32'(MAX_DEPTH));
  assign n_keep   = {1'b0, total_length} - two_w;
  assign low_core = n_keep < (LEN_BITS+1)'(2);

  // control
  fsm_t                        state, state_next;
  logic [CntBits-1:0]          step;
  logic signed [SAMPLE_BITS-1:0] new_sample;
  cell_ctl_t                   ctl;
  logic                        load;
  logic                        accept;

  logic signed [SAMPLE_BITS-1:0] hist [MAX_DEPTH];
  logic signed [SAMPLE_BITS-1:0] srt  [MAX_DEPTH];
  logic                          swp  [MAX_DEPTH];

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign new_sample = s_axis_tdata[SAMPLE_BITS-1:0];

  logic out_full;
  assign s_axis_tready = (state == S_IDLE) && !out_full;

  assign ctl.clear = rst || cfg_hit;
  assign ctl.shift = accept && !bad_cfg && !low_core;
  assign ctl.sort  = (state == S_SORT);

  // cell row
  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    logic in_win, last, lead, rok;
    logic signed [SAMPLE_BITS-1:0] hin, rv, lv;
    logic lsw;
    assign in_win = 32'(g) < 32'(total_length);
    assign last   = 32'(g) == 32'(total_length) - 1;
    assign lead   = (g % 2) == int'(step[0]);
    assign rok    = (g + 1 < MAX_DEPTH) && (32'(g + 1) < 32'(total_length));
    if (g + 1 < MAX_DEPTH) begin : g_r
      assign hin = hist[g+1];
      assign rv  = srt[g+1];
    end else begin : g_nr
      assign hin = '0;
      assign rv  = '0;
    end
    if (g > 0) begin : g_l
      assign lsw = swp[g-1];
      assign lv  = srt[g-1];
    end else begin : g_nl
      assign lsw = 1'b0;
      assign lv  = '0;
    end
    stmf_cell #(.SampleBits(SAMPLE_BITS)) u_cell (
      .clk(clk), .ctl(ctl), .active(in_win), .is_last(last),
      .hist_in(hin), .new_sample(new_sample), .hist(hist[g]),
      .sort_phase_ok(lead), .right_ok(rok), .right_val(rv),
      .left_swap(lsw), .left_val(lv), .load(load),
      .srt(srt[g]), .swap(swp[g])
    );
  end

  // warm-up check on the oldest slot after the shift
  logic [SAMPLE_BITS-1:0] mag;
  logic                   warm;
  assign mag  = hist[0][SAMPLE_BITS-1] ? SAMPLE_BITS'(-hist[0]) : hist[0];
  assign warm = 32'(mag) < 32'(zero_threshold);

  // summing walk over the sorted row
  logic signed [SumBits-1:0] sum;
  logic [IdxBits-1:0]        widx;
  logic signed [SumBits-1:0] term;
  logic [LEN_BITS:0]         hi_idx;
  assign widx   = step[IdxBits-1:0];
  assign hi_idx = {1'b0, total_length} - {2'b0, trim_count} - (LEN_BITS+1)'(1);
  always_comb begin
    term = '0;
    if (32'(step) >= 32'(trim_count) && 32'(step) <= 32'(hi_idx)) begin
      term = SumBits'(srt[widx]);
      if (32'(step) != 32'(trim_count) && 32'(step) != 32'(hi_idx)) begin
        term = term <<< 1;
      end
    end
  end

  // divider
  logic                div_start, div_done;
  logic [SumBits-1:0]  div_q;
  logic [SumBits-1:0]  sum_mag;
  logic [DenBits-1:0]  den;
  logic                neg;
  assign sum_mag   = sum[SumBits-1] ? SumBits'(-sum) : SumBits'(sum);
  assign den       = DenBits'({n_keep - (LEN_BITS+1)'(1), 1'b0});
  assign div_start = (state == S_SUM) && (32'(step) == MAX_DEPTH - 1);

  stmf_div #(.NumBits(SumBits), .DenBits(DenBits)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(sum_mag), .den(den),
    .done(div_done), .quo(div_q)
  );

  // output register
  logic [OUT_BITS-1:0]    o_filt;
  logic [STATUS_BITS-1:0] o_stat;
  logic                   o_warm;
  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {5'b0, o_warm, o_stat, o_filt};

  always_comb begin
    state_next = state;
    load = 1'b0;
    unique case (state)
      S_IDLE: if (accept && !bad_cfg && !low_core) state_next = S_OUT;
      S_OUT: begin
        if (!warm) begin
          state_next = S_SORT;
          load = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SORT: if (32'(step) == MAX_DEPTH - 1) state_next = S_SUM;
      S_SUM:  if (32'(step) == MAX_DEPTH - 1) state_next = S_DIV;
      S_DIV:  if (div_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (out_full && m_axis_tready) out_full <= 1'b0;
      if (state != state_next) step <= '0;
      else step <= step + 1'b1;
      if (state == S_IDLE && accept) begin
        neg <= 1'b0;
        if (bad_cfg || low_core) begin
          out_full <= 1'b1;
          o_filt   <= '0;
          o_warm   <= 1'b0;
          o_stat   <= bad_cfg ? ST_BAD_CFG : ST_CORE_LOW;
        end
      end
      if (state == S_OUT && warm) begin
        out_full <= 1'b1;
        o_filt   <= '0;
        o_warm   <= 1'b1;
        o_stat   <= ST_OK;
      end
      if (state == S_SORT && state_next == S_SUM) sum <= '0;
      if (state == S_SUM) sum <= sum + term;
      if (div_start) neg <= sum[SumBits-1];
      if (state == S_DIV && div_done) begin
        out_full <= 1'b1;
        o_filt   <= neg ? OUT_BITS'(-div_q) : OUT_BITS'(div_q);
        o_warm   <= 1'b0;
        o_stat   <= ST_OK;
      end
    end
  end

`ifndef ASSERT_OFF
  // only one item in flight: no new input while a result waits
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !s_axis_tready) else $error("input taken with result pending");
  // divider only finishes while waiting on it
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV) else $error("divider done out of state");
  // a warm result is never flagged with bad status
  a_warm_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && o_warm) |-> o_stat == ST_OK) else $error("warm with bad status");
  // output held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
`endif
endmodule

### rtl/core/stmf_cell.sv
// stmf_cell: one history slot plus one sorted slot of the cell row
// depends on stmf_pkg
`timescale 1ns / 1ps
module stmf_cell #(
  parameter int SampleBits = 16
) (
  input  logic                         clk,
  input  stmf_pkg::cell_ctl_t          ctl,
  input  logic                         active,     // slot lies inside the window
  input  logic                         is_last,    // newest slot of the window
  input  logic signed [SampleBits-1:0] hist_in,    // from newer neighbor
  input  logic signed [SampleBits-1:0] new_sample,
  output logic signed [SampleBits-1:0] hist,
  // odd-even transposition: compare with right neighbor
  input  logic                         sort_phase_ok, // this cell leads a pair now
  input  logic                         right_ok,      // pair inside window
  input  logic signed [SampleBits-1:0] right_val,
  input  logic                         left_swap,     // left pair swapped
  input  logic signed [SampleBits-1:0] left_val,
  input  logic                         load,
  output logic signed [SampleBits-1:0] srt,
  output logic                         swap
);
  import stmf_pkg::*;

  assign swap = sort_phase_ok && right_ok && (srt > right_val);

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hist <= '0;
    end else if (ctl.shift && active) begin
      hist <= is_last ? new_sample : hist_in;
    end
    if (load) begin
      srt <= hist;
    end else if (ctl.sort) begin
      if (swap) begin
        srt <= right_val;
      end else if (left_swap) begin
        srt <= left_val;
      end
    end
  end
endmodule

### rtl/core/stmf_div.sv
// stmf_div: restoring divider for magnitude / divisor, one quotient bit a cycle
// depends on stmf_pkg
`timescale 1ns / 1ps
module stmf_div #(
  parameter int NumBits = 24,
  parameter int DenBits = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NumBits-1:0] num,
  input  logic [DenBits-1:0] den,
  output logic               done,
  output logic [NumBits-1:0] quo
);
  import stmf_pkg::*;
  localparam int CntBits = $clog2(NumBits + 1);

  logic [DenBits:0]   rem;
  logic [DenBits:0]   trial;
  logic [NumBits-1:0] nsh;
  logic [DenBits-1:0] dreg;
  logic [CntBits-1:0] cnt;
  logic               busy;

  assign trial = {rem[DenBits-1:0], nsh[NumBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(NumBits);
        rem  <= '0;
        nsh  <= num;
        dreg <= den;
      end else if (busy) begin
        nsh <= nsh << 1;
        if (trial >= {1'b0, dreg}) begin
          rem <= trial - {1'b0, dreg};
          quo <= {quo[NumBits-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NumBits-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
